// ===== hw/rtl/lkv_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
package lkv_pkg;

	// Field widths fixed by the request and result words
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int CAP_BITS   = 5;

	// Capacity after reset
	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	// Request modes
	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;

	// Value returned by a get that misses
	localparam logic signed [VALUE_BITS-1:0] MISS_VALUE = '1;

	// Request word
	typedef struct packed {
		logic                          mode;
		logic signed [KEY_BITS-1:0]    lookup_key;
		logic signed [VALUE_BITS-1:0]  store_value;
	} req_t;

	// Result word
	typedef struct packed {
		logic                          hit;
		logic signed [VALUE_BITS-1:0]  read_value;
		logic                          evicted;
	} rsp_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic match;
		logic apply;
	} cmd_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_MATCH = 3'b010,
		ST_APPLY = 3'b100
	} state_t;

endpackage

// ===== hw/rtl/lkv_ctrl.sv =====
// Sequencing controller for the LRU key-value cache.
module lkv_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output lkv_pkg::cmd_t cmd
);

	lkv_pkg::state_t state_q;
	lkv_pkg::state_t state_d;

	// Step idle -> match -> apply -> idle
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lkv_pkg::ST_IDLE: begin
				if (start) state_d = lkv_pkg::ST_MATCH;
			end
			lkv_pkg::ST_MATCH: begin
				state_d = lkv_pkg::ST_APPLY;
			end
			lkv_pkg::ST_APPLY: begin
				state_d = lkv_pkg::ST_IDLE;
			end
			default: begin
				state_d = lkv_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Drive datapath commands
	assign busy      = (state_q != lkv_pkg::ST_IDLE);
	assign cmd.load  = (state_q == lkv_pkg::ST_IDLE) && start;
	assign cmd.match = (state_q == lkv_pkg::ST_MATCH);
	assign cmd.apply = (state_q == lkv_pkg::ST_APPLY);

	a_accept_to_match: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == lkv_pkg::ST_MATCH)
		else $error("accepted word did not enter match");

	a_match_to_apply: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lkv_pkg::ST_MATCH |=> state_q == lkv_pkg::ST_APPLY)
		else $error("match not followed by apply");

	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.match, cmd.apply}))
		else $error("more than one datapath command at once");

endmodule

// ===== hw/rtl/lkv_datapath.sv =====
// Key store, value memory, recency ranks and result register of the LRU cache.
module lkv_datapath #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lkv_pkg::cmd_t                     cmd,
	input  lkv_pkg::req_t                     req,
	input  logic                              cfg_we,
	input  logic [lkv_pkg::CAP_BITS-1:0]      cfg_wdata,
	output logic                              done,
	output lkv_pkg::rsp_t                     rsp
);

	localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int RANK_W = IDX_W;
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W  = (CNT_W > lkv_pkg::CAP_BITS) ? CNT_W : lkv_pkg::CAP_BITS;
	localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_ENTRIES);

	// Lowest set bit of a vector
	function automatic logic [IDX_W-1:0] first_set(input logic [MAX_ENTRIES-1:0] vec);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (vec[i]) idx = IDX_W'(i);
		end
		return idx;
	endfunction

	// Stored state
	logic [MAX_ENTRIES-1:0]               valid_q;
	logic [lkv_pkg::KEY_BITS-1:0]         key_q   [MAX_ENTRIES];
	logic [RANK_W-1:0]                    rank_q  [MAX_ENTRIES];
	logic [lkv_pkg::VALUE_BITS-1:0]       value_mem [MAX_ENTRIES];
	logic [CNT_W-1:0]                     count_q;
	logic [lkv_pkg::CAP_BITS-1:0]         cap_q;
	lkv_pkg::req_t                        req_q;

	// Match stage results
	logic                                 hit_s1;
	logic [IDX_W-1:0]                     found_idx_s1;
	logic [RANK_W-1:0]                    found_rank_s1;
	logic [IDX_W-1:0]                     slot_idx_s1;
	logic                                 evict_s1;
	logic [MAX_ENTRIES-1:0]               victim_s1;
	logic [lkv_pkg::VALUE_BITS-1:0]       rd_data_s1;

	// Result register
	lkv_pkg::rsp_t                        rsp_q;
	logic                                 done_q;

	// Match logic
	logic [MAX_ENTRIES-1:0]               match_vec;
	logic [MAX_ENTRIES-1:0]               victim_vec;
	logic [MAX_ENTRIES-1:0]               free_vec;
	logic [IDX_W-1:0]                     found_idx;
	logic [RANK_W-1:0]                    oldest_rank;
	logic [CNT_W-1:0]                     count_m1;
	logic [CMP_W-1:0]                     cap_eff;
	logic [CMP_W-1:0]                     count_cmp;
	logic                                 need_evict;
	logic                                 evict;

	// Apply logic
	logic                                 is_put;
	logic                                 put_miss;
	logic [IDX_W-1:0]                     tgt_idx;
	logic [MAX_ENTRIES-1:0]               age_vec;
	logic [MAX_ENTRIES-1:0]               slot_onehot;

	// Clamp capacity to the range one .. MAX_ENTRIES
	always_comb begin
		cap_eff = CMP_W'(cap_q);
		if (cap_q == '0) cap_eff = CMP_W'(1);
		if (cap_eff > MAX_CMP) cap_eff = MAX_CMP;
	end

	// Compare all keys, locate the least recent entry and a free slot
	assign count_m1    = count_q - CNT_W'(1);
	assign oldest_rank = count_m1[RANK_W-1:0];
	assign count_cmp   = CMP_W'(count_q);
	assign need_evict  = (count_cmp >= cap_eff) && (count_q != '0);

	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			match_vec[i]  = valid_q[i] && (key_q[i] == req_q.lookup_key);
			victim_vec[i] = valid_q[i] && (rank_q[i] == oldest_rank);
		end
	end

	assign found_idx = first_set(match_vec);
	assign evict     = need_evict && (|victim_vec);
	assign free_vec  = ~valid_q | (evict ? victim_vec : '0);

	// Ranks age among entries touched by this word
	assign is_put   = (req_q.mode == lkv_pkg::MODE_PUT);
	assign put_miss = is_put && !hit_s1;
	assign tgt_idx  = hit_s1 ? found_idx_s1 : slot_idx_s1;

	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			slot_onehot[i] = (slot_idx_s1 == IDX_W'(i));
			age_vec[i] = valid_q[i] && (tgt_idx != IDX_W'(i)) &&
				(hit_s1 ? (rank_q[i] < found_rank_s1) : !victim_s1[i]);
		end
	end

	// Capture request and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkv_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
	end

	// Hold match results for the apply step
	always_ff @(posedge clk) begin
		if (cmd.match) begin
			hit_s1        <= |match_vec;
			found_idx_s1  <= found_idx;
			found_rank_s1 <= rank_q[found_idx];
			slot_idx_s1   <= first_set(free_vec);
			evict_s1      <= evict;
			victim_s1     <= evict ? victim_vec : '0;
		end
	end

	// Value memory: read at match, write at apply
	always_ff @(posedge clk) begin
		if (cmd.match) rd_data_s1 <= value_mem[found_idx];
		if (cmd.apply && is_put) value_mem[tgt_idx] <= req_q.store_value;
	end

	// Key store
	always_ff @(posedge clk) begin
		if (cmd.apply && put_miss) key_q[slot_idx_s1] <= req_q.lookup_key;
	end

	// Valid bits, ranks and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) rank_q[i] <= '0;
		end else if (cmd.apply && (hit_s1 || is_put)) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (tgt_idx == IDX_W'(i)) begin
					rank_q[i] <= '0;
				end else if (age_vec[i]) begin
					rank_q[i] <= rank_q[i] + RANK_W'(1);
				end
			end
			if (put_miss) begin
				valid_q <= (valid_q & ~victim_s1) | slot_onehot;
				if (!evict_s1) count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// Result word, shown for one cycle after apply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.apply;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			rsp_q.hit     <= hit_s1;
			rsp_q.evicted <= put_miss && evict_s1;
			if (is_put) begin
				rsp_q.read_value <= '0;
			end else if (hit_s1) begin
				rsp_q.read_value <= rd_data_s1;
			end else begin
				rsp_q.read_value <= lkv_pkg::MISS_VALUE;
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q))
		else $error("entry count differs from number of valid entries");

	a_done_after_apply: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cmd.apply))
		else $error("result strobe without an apply step");

	a_evict_is_put_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && rsp_q.evicted |-> !rsp_q.hit && rsp_q.read_value == '0)
		else $error("eviction reported outside a put miss");

endmodule

// ===== hw/rtl/lru_key_value_cache_top.sv =====
// Top level of the fully associative LRU key-value cache.
//
// Request channel: raise start with a word on req (mode, lookup_key,
// store_value). The word is taken at a clock edge where start is high and
// busy is low. busy stays high through the match and apply steps that follow.
// Result channel: done pulses for one cycle with the word on rsp (hit,
// read_value, evicted). The receiver cannot hold it off; take it then.
// Sequence: each word passes through the controller steps in order: the
// accepting cycle, then key compare and value memory read, then rank and
// store update, with the result register loaded at the end of the update
// and done raised with it. A new word is accepted in the cycle that shows
// the previous result; no new word is taken while busy is high.
// Configuration: cfg_we with cfg_wdata writes the capacity (0 acts as 1,
// values above MAX_ENTRIES act as MAX_ENTRIES); write it only while idle.
// Reset: arst_n clears all entries, the count and the ranks, and sets the
// capacity to 16. No clearing pass is needed.
module lru_key_value_cache_top #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  lkv_pkg::req_t                     req,
	output logic                              done,
	output lkv_pkg::rsp_t                     rsp,
	input  logic                              cfg_we,
	input  logic [lkv_pkg::CAP_BITS-1:0]      cfg_wdata
);

	lkv_pkg::cmd_t cmd;

	lkv_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	lkv_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.rsp       (rsp)
	);

endmodule
